>>> rtl/assert_macros.svh
// Assertion macros for the divider RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RIDIV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("divider assertion failed");
`define RIDIV_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(prop)) \
    else $error("divider forbidden condition seen");
`else
`define RIDIV_ASSERT(lbl, clk, rstn, prop)
`define RIDIV_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

>>> rtl/ridiv_pkg.sv
// Types, constants and codes shared by the integer divider modules.
package ridiv_pkg;

  localparam int unsigned XLEN         = 32;
  localparam int unsigned STEPS        = XLEN / 2;
  localparam int unsigned CNT_W        = $clog2(STEPS);
  localparam int unsigned TAG_BITS_DEF = 5;

  // Operation codes and the bits that carry their meaning
  localparam logic [1:0] KIND_DIV  = 2'd0;
  localparam logic [1:0] KIND_DIVU = 2'd1;
  localparam logic [1:0] KIND_REM  = 2'd2;
  localparam logic [1:0] KIND_REMU = 2'd3;
  localparam int unsigned KIND_UNSIGNED_BIT = 0;
  localparam int unsigned KIND_REM_BIT      = 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_ITER  = 4'b0100,
    ST_FIX   = 4'b1000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic early;
  } status_t;

endpackage

>>> rtl/ridiv_ctrl.sv
// Sequencer for the divider: accept, range check, digit steps, result hand-off.
module ridiv_ctrl import ridiv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             last_step;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_step   = (cnt_q == CNT_W'(STEPS - 1));

  // Decode state into datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.check    = (state_q == ST_CHECK);
    cmd_o.step     = (state_q == ST_ITER);
    cmd_o.out_load = (state_q == ST_FIX) && out_free;
  end

  // Advance the sequence
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cnt_d   = '0;
        state_d = status_i.early ? ST_FIX : ST_ITER;
      end
      ST_ITER: begin
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/ridiv_dpath.sv
// Divider datapath: operand magnitudes, radix-4 digit loop and sign fix-up.
module ridiv_dpath import ridiv_pkg::*; #(
  parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
  input  logic                clk_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic [1:0]          kind_i,
  input  logic [XLEN-1:0]     dividend_i,
  input  logic [XLEN-1:0]     divisor_i,
  input  logic [TAG_BITS-1:0] rob_tag_i,
  output logic [XLEN-1:0]     result_o,
  output logic [TAG_BITS-1:0] result_tag_o
);

  logic [XLEN-1:0]     quo_q;   // dividend magnitude, then quotient bits
  logic [XLEN-1:0]     ad_q;
  logic [XLEN+1:0]     d3_q;
  logic [XLEN-1:0]     rem_q;
  logic                xneg_q, qneg_q, dzero_q, want_rem_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [XLEN-1:0]     res_q;
  logic [TAG_BITS-1:0] res_tag_q;

  logic            is_signed, xneg, dneg;
  logic [XLEN-1:0] ax, ad;
  logic [XLEN+1:0] shr;
  logic [XLEN+2:0] diff1, diff2, diff3;
  logic [1:0]      digit;
  logic [XLEN-1:0] rem_next;
  logic [XLEN-1:0] quo_fix, rem_fix;

  // Operand magnitudes
  assign is_signed = !kind_i[KIND_UNSIGNED_BIT];
  assign xneg      = is_signed && dividend_i[XLEN-1];
  assign dneg      = is_signed && divisor_i[XLEN-1];
  assign ax        = xneg ? (~dividend_i + 1'b1) : dividend_i;
  assign ad        = dneg ? (~divisor_i + 1'b1) : divisor_i;

  // Short cases: zero divisor or dividend magnitude not above divisor
  assign status_o.early = dzero_q || (quo_q <= ad_q);

  // Pick the largest multiple of the divisor that fits the shifted remainder
  assign shr   = {rem_q, quo_q[XLEN-1:XLEN-2]};
  assign diff1 = {1'b0, shr} - {3'b000, ad_q};
  assign diff2 = {1'b0, shr} - {2'b00, ad_q, 1'b0};
  assign diff3 = {1'b0, shr} - {1'b0, d3_q};

  always_comb begin
    digit    = 2'd0;
    rem_next = shr[XLEN-1:0];
    if (!diff3[XLEN+2]) begin
      digit    = 2'd3;
      rem_next = diff3[XLEN-1:0];
    end else if (!diff2[XLEN+2]) begin
      digit    = 2'd2;
      rem_next = diff2[XLEN-1:0];
    end else if (!diff1[XLEN+2]) begin
      digit    = 2'd1;
      rem_next = diff1[XLEN-1:0];
    end
  end

  // Apply signs
  assign quo_fix = (qneg_q && !dzero_q) ? (~quo_q + 1'b1) : quo_q;
  assign rem_fix = xneg_q ? (~rem_q + 1'b1) : rem_q;

  // Load operands, resolve short cases, iterate
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quo_q      <= ax;
      ad_q       <= ad;
      xneg_q     <= xneg;
      qneg_q     <= xneg ^ dneg;
      dzero_q    <= (divisor_i == '0);
      want_rem_q <= kind_i[KIND_REM_BIT];
      tag_q      <= rob_tag_i;
    end
    if (cmd_i.check) begin
      d3_q <= {2'b00, ad_q} + {1'b0, ad_q, 1'b0};
      if (dzero_q) begin
        quo_q <= '1;
        rem_q <= quo_q;
      end else if (quo_q < ad_q) begin
        quo_q <= '0;
        rem_q <= quo_q;
      end else if (quo_q == ad_q) begin
        quo_q <= XLEN'(1);
        rem_q <= '0;
      end else begin
        rem_q <= '0;
      end
    end
    if (cmd_i.step) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[XLEN-3:0], digit};
    end
    if (cmd_i.out_load) begin
      res_q     <= want_rem_q ? rem_fix : quo_fix;
      res_tag_q <= tag_q;
    end
  end

  assign result_o     = res_q;
  assign result_tag_o = res_tag_q;

endmodule

>>> rtl/riscv_integer_divider.sv
// Sequence per word: range check, then 16 radix-4 digit steps unless |dividend| <=
// |divisor| or the divisor is zero, then sign fix-up into the output register.
// Each step compares against one, two and three times the divisor. The fix-up
// waits while a stalled result is held. The next word is taken once the
// result sits in the output register. Reset clears the sequencer and valids.
module riscv_integer_divider import ridiv_pkg::*; #(
  parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [XLEN-1:0]     dividend_i,
  input  logic [XLEN-1:0]     divisor_i,
  input  logic [TAG_BITS-1:0] rob_tag_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [XLEN-1:0]     result_o,
  output logic [TAG_BITS-1:0] result_tag_o
);

`include "assert_macros.svh"

  cmd_t    cmd;
  status_t status;

  ridiv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ridiv_dpath #(
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .kind_i       (kind_i),
    .dividend_i   (dividend_i),
    .divisor_i    (divisor_i),
    .rob_tag_i    (rob_tag_i),
    .result_o     (result_o),
    .result_tag_o (result_tag_o)
  );

  `RIDIV_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `RIDIV_ASSERT(a_result_shown, clk_i, rst_ni, cmd.out_load |=> out_valid_o)
  `RIDIV_ASSERT(a_one_command, clk_i, rst_ni, $onehot0({cmd.load, cmd.check, cmd.step, cmd.out_load}))
  `RIDIV_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.out_load && out_valid_o && out_stall_i)

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the RISC-V integer divider: directed corners, then random words.
module testbench import ridiv_pkg::*; ();

  localparam int unsigned TAG_W      = TAG_BITS_DEF;
  localparam int unsigned HOLD_LEN   = 120;
  localparam int unsigned RAND_WORDS = 1000;
  localparam int unsigned DRAIN_LEN  = 40;

  // One directed row: operands, tag, and an optional typed-in answer
  typedef struct packed {
    logic [1:0]      kind;
    logic [XLEN-1:0] dividend;
    logic [XLEN-1:0] divisor;
    logic [TAG_W-1:0] tag;
    logic            fixed;
    logic [XLEN-1:0] want;
  } div_vec_t;

  typedef struct {
    logic [XLEN-1:0]  value;
    logic [TAG_W-1:0] tag;
  } div_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          kind_i;
  logic [XLEN-1:0]     dividend_i;
  logic [XLEN-1:0]     divisor_i;
  logic [TAG_W-1:0]    rob_tag_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [XLEN-1:0]     result_o;
  logic [TAG_W-1:0]    result_tag_o;

  // Answer attached to the word on the input port, when typed in by hand
  logic                cur_fixed;
  logic [XLEN-1:0]     cur_want;

  // Phase controls shared by sender and receiver
  logic                no_idle;
  int unsigned         hold_reqs;

  div_result_t         pending_results[$];
  int unsigned         mismatch_cnt;

  div_vec_t directed_vecs [0:24] = '{
    '{KIND_DIVU, 32'hFFFF_FFFF, 32'h0000_0000, 5'd31, 1'b1, 32'hFFFF_FFFF},
    '{KIND_DIV,  32'h0000_0005, 32'h0000_0000, 5'd0,  1'b1, 32'hFFFF_FFFF},
    '{KIND_REM,  32'h8000_0000, 32'h0000_0000, 5'd1,  1'b1, 32'h8000_0000},
    '{KIND_REMU, 32'h1234_5678, 32'h0000_0000, 5'd2,  1'b1, 32'h1234_5678},
    '{KIND_DIV,  32'h8000_0000, 32'hFFFF_FFFF, 5'd3,  1'b1, 32'h8000_0000},
    '{KIND_REM,  32'h8000_0000, 32'hFFFF_FFFF, 5'd4,  1'b1, 32'h0000_0000},
    '{KIND_DIVU, 32'h8000_0000, 32'hFFFF_FFFF, 5'd5,  1'b1, 32'h0000_0000},
    '{KIND_REMU, 32'h8000_0000, 32'hFFFF_FFFF, 5'd6,  1'b1, 32'h8000_0000},
    '{KIND_DIVU, 32'hFFFF_FFFF, 32'h0000_0001, 5'd7,  1'b1, 32'hFFFF_FFFF},
    '{KIND_DIVU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd8,  1'b1, 32'h0000_0001},
    '{KIND_REMU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd9,  1'b1, 32'h0000_0000},
    '{KIND_DIV,  32'hFFFF_FFFF, 32'h0000_0001, 5'd10, 1'b1, 32'hFFFF_FFFF},
    '{KIND_DIV,  32'h0000_0000, 32'h8000_0000, 5'd11, 1'b1, 32'h0000_0000},
    '{KIND_DIV,  32'h8000_0000, 32'h8000_0000, 5'd12, 1'b1, 32'h0000_0001},
    '{KIND_REM,  32'h8000_0000, 32'h8000_0000, 5'd13, 1'b1, 32'h0000_0000},
    '{KIND_DIV,  32'h7FFF_FFFF, 32'h8000_0001, 5'd14, 1'b1, 32'hFFFF_FFFF},
    '{KIND_REM,  32'h0000_0003, 32'hFFFF_FFF9, 5'd15, 1'b1, 32'h0000_0003},
    '{KIND_DIV,  32'h8000_0000, 32'h0000_0001, 5'd16, 1'b1, 32'h8000_0000},
    '{KIND_DIVU, 32'h0000_0001, 32'hFFFF_FFFF, 5'd17, 1'b1, 32'h0000_0000},
    '{KIND_DIV,  32'hFFFF_FFF9, 32'h0000_0002, 5'd18, 1'b0, 32'h0000_0000},
    '{KIND_REM,  32'hFFFF_FFF9, 32'h0000_0002, 5'd19, 1'b0, 32'h0000_0000},
    '{KIND_DIV,  32'h0000_0007, 32'hFFFF_FFFE, 5'd20, 1'b0, 32'h0000_0000},
    '{KIND_REMU, 32'h0000_0064, 32'h0000_0007, 5'd21, 1'b0, 32'h0000_0000},
    '{KIND_DIVU, 32'h7FFF_FFFF, 32'h0000_0003, 5'd22, 1'b0, 32'h0000_0000},
    '{KIND_REM,  32'h7FFF_FFFF, 32'h8000_0000, 5'd23, 1'b0, 32'h0000_0000}
  };

  riscv_integer_divider #(
    .TAG_BITS(TAG_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .dividend_i  (dividend_i),
    .divisor_i   (divisor_i),
    .rob_tag_i   (rob_tag_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .result_tag_o(result_tag_o)
  );

  // Quotient or remainder with RISC-V rules for zero divisor and overflow
  function automatic logic [XLEN-1:0] divide_rv(logic [1:0] kind, logic [XLEN-1:0] x,
                                                logic [XLEN-1:0] d);
    logic            x_neg;
    logic            d_neg;
    logic [XLEN-1:0] ax;
    logic [XLEN-1:0] ad;
    logic [XLEN-1:0] mq;
    logic [XLEN-1:0] mr;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] rem;
    if (d == '0) begin
      quo = '1;
      rem = x;
    end else if (!kind[KIND_UNSIGNED_BIT]) begin
      x_neg = x[XLEN-1];
      d_neg = d[XLEN-1];
      ax    = x_neg ? ('0 - x) : x;
      ad    = d_neg ? ('0 - d) : d;
      mq    = ax / ad;
      mr    = ax % ad;
      quo   = (x_neg != d_neg) ? ('0 - mq) : mq;
      rem   = x_neg ? ('0 - mr) : mr;
    end else begin
      quo = x / d;
      rem = x % d;
    end
    return kind[KIND_REM_BIT] ? rem : quo;
  endfunction

  // Operand mix: full range, every bit length, small values and corners
  function automatic logic [XLEN-1:0] pick_operand();
    logic [XLEN-1:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2: return raw;
      3, 4:    return raw >> $urandom_range(0, XLEN - 1);
      5:       return XLEN'($urandom_range(0, 15));
      6:       return '0 - XLEN'($urandom_range(1, 15));
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return '1;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(logic [1:0] kind, logic [XLEN-1:0] x, logic [XLEN-1:0] d,
                           logic [TAG_W-1:0] tag, logic fixed, logic [XLEN-1:0] want);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i     = kind;
    dividend_i = x;
    divisor_i  = d;
    rob_tag_i  = tag;
    cur_fixed  = fixed;
    cur_want   = want;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Check each delivered word, then record the word taken at the input
  always @(posedge clk_i) begin
    div_result_t exp_res;
    div_result_t new_res;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected result %h tag %0d", result_o, result_tag_o);
          mismatch_cnt++;
        end else begin
          exp_res = pending_results.pop_front();
          if (result_o !== exp_res.value || result_tag_o !== exp_res.tag) begin
            if (mismatch_cnt < 10)
              $display("result mismatch: expected %h tag %0d, got %h tag %0d",
                       exp_res.value, exp_res.tag, result_o, result_tag_o);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        new_res.value = cur_fixed ? cur_want : divide_rv(kind_i, dividend_i, divisor_i);
        new_res.tag   = rob_tag_i;
        pending_results.push_back(new_res);
      end
    end
  end

  // Result side: random stall per word, plus long hold-offs on request
  initial begin
    int unsigned wait_left;
    int unsigned hold_left;
    int unsigned holds_seen;
    wait_left   = 0;
    hold_left   = 0;
    holds_seen  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        wait_left = no_idle ? 0 : $urandom_range(0, 6);
      if (holds_seen != hold_reqs) begin
        holds_seen = hold_reqs;
        hold_left  = HOLD_LEN;
      end
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (wait_left > 0) begin
        out_stall_i = 1'b1;
        wait_left--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Reset, directed table, random words, drain and verdict
  initial begin
    logic [1:0]      kind;
    logic [XLEN-1:0] x;
    logic [XLEN-1:0] d;
    int unsigned     leftover;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_DIV;
    dividend_i   = '0;
    divisor_i    = '0;
    rob_tag_i    = '0;
    cur_fixed    = 1'b0;
    cur_want     = '0;
    no_idle      = 1'b0;
    hold_reqs    = 0;
    mismatch_cnt = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_vecs[i])
      send_word(directed_vecs[i].kind, directed_vecs[i].dividend, directed_vecs[i].divisor,
                directed_vecs[i].tag, directed_vecs[i].fixed, directed_vecs[i].want);

    for (int i = 0; i < RAND_WORDS; i++) begin
      // Run a stretch back to back with no gaps on either side
      no_idle = (i >= 300 && i < 420);
      // Hold off the result side while the sender keeps offering words
      if (i == 550)
        hold_reqs++;
      // Pause until every result is back
      if (i == 800) begin
        in_valid_i = 1'b0;
        while (pending_results.size() != 0) @(negedge clk_i);
      end
      kind = 2'($urandom);
      x    = pick_operand();
      d    = pick_operand();
      case ($urandom_range(0, 31))
        0, 1: d = x;
        2:    d = '0 - x;
        3: begin
          x = 32'h8000_0000;
          d = '1;
        end
        default: ;
      endcase
      send_word(kind, x, d, TAG_W'($urandom), 1'b0, '0);
    end

    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_LEN) @(negedge clk_i);
    leftover = pending_results.size();
    if (leftover != 0)
      $display("%0d results never arrived", leftover);
    if (mismatch_cnt == 0 && leftover == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
